[rtl/leb_pkg.sv]
// ----------------------------------------------------------------------------
// leb_pkg
// Shared constants, key codes and control types for the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
    localparam int READ_W        = 6;
    localparam int CMP_W         = (CNT_W > READ_W) ? CNT_W : READ_W;
    localparam int OUT_CNT_W     = 7;

    localparam logic [7:0] KEY_CTRL_A = 8'h01;
    localparam logic [7:0] KEY_CTRL_B = 8'h02;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_E = 8'h05;
    localparam logic [7:0] KEY_CTRL_F = 8'h06;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_CTRL_K = 8'h0b;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_SPACE  = 8'h20;
    localparam logic [7:0] KEY_DEL    = 8'h7f;

    // what the row of cells does on one beat
    typedef struct packed {
        logic             insert;
        logic             remove;
        logic [CNT_W-1:0] pos;
        logic [7:0]       key;
    } t_edit_ctrl;

endpackage

[rtl/leb_cell.sv]
// ----------------------------------------------------------------------------
// leb_cell
// One character position: holds a byte, takes the left or right neighbor's
// byte when the line shifts, and drives its byte on a matching read.
// ----------------------------------------------------------------------------
module leb_cell (
    input  logic                      i_clk,
    input  logic [leb_pkg::CNT_W-1:0] i_index,
    input  logic                      i_enable,
    input  leb_pkg::t_edit_ctrl       i_edit,
    input  logic [7:0]                i_left_char,
    input  logic [7:0]                i_right_char,
    input  logic [leb_pkg::READ_W-1:0] i_read_index,
    output logic [7:0]                o_char,
    output logic [7:0]                o_read_data
);
    import leb_pkg::*;

    logic [7:0] r_char;
    logic [7:0] n_char;
    logic       read_hit;

    always_comb begin
        n_char = r_char;
        if (i_edit.insert) begin
            if (i_index > i_edit.pos) begin
                n_char = i_left_char;
            end else if (i_index == i_edit.pos) begin
                n_char = i_edit.key;
            end
        end else if (i_edit.remove) begin
            if (i_index >= i_edit.pos) begin
                n_char = i_right_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enable) begin
            r_char <= n_char;
        end
    end

    assign read_hit    = (CMP_W'(i_index) == CMP_W'(i_read_index));
    assign o_char      = r_char;
    assign o_read_data = read_hit ? r_char : 8'h00;

endmodule

[rtl/leb_ctrl.sv]
// ----------------------------------------------------------------------------
// leb_ctrl
// Key decoder: next cursor and length, and the shift command for the cells.
// ----------------------------------------------------------------------------
module leb_ctrl (
    input  logic                      i_req_type,
    input  logic [7:0]                i_key_byte,
    input  logic [leb_pkg::CNT_W-1:0] i_cursor,
    input  logic [leb_pkg::CNT_W-1:0] i_count,
    output logic [leb_pkg::CNT_W-1:0] o_cursor,
    output logic [leb_pkg::CNT_W-1:0] o_count,
    output logic                      o_dropped,
    output leb_pkg::t_edit_ctrl       o_edit
);
    import leb_pkg::*;

    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

    always_comb begin
        o_cursor    = i_cursor;
        o_count     = i_count;
        o_dropped   = 1'b0;
        o_edit      = '0;
        o_edit.pos  = i_cursor;
        o_edit.key  = i_key_byte;
        if (!i_req_type) begin
            case (i_key_byte)
                KEY_BS, KEY_DEL: begin
                    if (i_cursor != '0) begin
                        o_cursor      = i_cursor - ONE;
                        o_count       = i_count - ONE;
                        o_edit.remove = 1'b1;
                        o_edit.pos    = i_cursor - ONE;
                    end
                end
                KEY_CTRL_D: begin
                    if (i_count > i_cursor) begin
                        o_count       = i_count - ONE;
                        o_edit.remove = 1'b1;
                    end
                end
                KEY_CTRL_U: begin
                    o_cursor = '0;
                    o_count  = '0;
                end
                KEY_CTRL_A: o_cursor = '0;
                KEY_CTRL_E: o_cursor = i_count;
                KEY_CTRL_F: begin
                    if (i_cursor < i_count) begin
                        o_cursor = i_cursor + ONE;
                    end
                end
                KEY_CTRL_B: begin
                    if (i_cursor != '0) begin
                        o_cursor = i_cursor - ONE;
                    end
                end
                KEY_CTRL_K: o_count = i_cursor;
                default: begin
                    if (i_key_byte >= KEY_SPACE) begin
                        if (i_count >= CAP) begin
                            o_dropped = 1'b1;
                        end else begin
                            o_cursor      = i_cursor + ONE;
                            o_count       = i_count + ONE;
                            o_edit.insert = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

[rtl/line_edit_buffer.sv]
// ----------------------------------------------------------------------------
// line_edit_buffer
// Line editor with a cursor, built as a row of character cells that shift
// left or right against the cursor position on each edit beat.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | i_valid / o_stall    | i_req_type, i_key_byte, i_read_index
//   output  | o_valid / i_stall    | o_cursor, o_line_length, o_read_char,
//           |                      | o_insert_dropped
//
// On every beat all cells shift in parallel, and a read picks its cell
// through a per-cell match into the output register.
// Synchronous active-low reset empties the line; cell contents are not reset.
// A new beat is taken while the output register is empty or being drained,
// so back-to-back beats run at one per cycle while the sink does not stall.
// ----------------------------------------------------------------------------
module line_edit_buffer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_req_type,
    input  logic [7:0]                  i_key_byte,
    input  logic [leb_pkg::READ_W-1:0]  i_read_index,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [leb_pkg::OUT_CNT_W-1:0] o_cursor,
    output logic [leb_pkg::OUT_CNT_W-1:0] o_line_length,
    output logic [7:0]                  o_read_char,
    output logic                        o_insert_dropped
);
    import leb_pkg::*;

    logic [CNT_W-1:0] r_cursor;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_cursor;
    logic [CNT_W-1:0] n_count;
    logic             dropped;
    t_edit_ctrl       edit;
    logic             accept;

    logic             r_out_valid;
    logic [OUT_CNT_W-1:0] r_out_cursor;
    logic [OUT_CNT_W-1:0] r_out_length;
    logic [7:0]       r_out_char;
    logic             r_out_dropped;

    logic [7:0]       cell_char [LINE_CAPACITY];
    logic [7:0]       cell_read [LINE_CAPACITY];
    logic [7:0]       read_mux;
    logic [7:0]       read_char;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    leb_ctrl u_ctrl (
        .i_req_type (i_req_type),
        .i_key_byte (i_key_byte),
        .i_cursor   (r_cursor),
        .i_count    (r_count),
        .o_cursor   (n_cursor),
        .o_count    (n_count),
        .o_dropped  (dropped),
        .o_edit     (edit)
    );

    for (genvar g = 0; g < LINE_CAPACITY; g++) begin : g_cell
        logic [7:0] left_char;
        logic [7:0] right_char;

        if (g == 0) begin : g_first
            assign left_char = 8'h00;
        end else begin : g_mid_l
            assign left_char = cell_char[g-1];
        end
        if (g == LINE_CAPACITY - 1) begin : g_last
            assign right_char = 8'h00;
        end else begin : g_mid_r
            assign right_char = cell_char[g+1];
        end

        leb_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (CNT_W'(g)),
            .i_enable     (accept),
            .i_edit       (edit),
            .i_left_char  (left_char),
            .i_right_char (right_char),
            .i_read_index (i_read_index),
            .o_char       (cell_char[g]),
            .o_read_data  (cell_read[g])
        );
    end

    // at most one cell matches, so an or of all cells picks it
    always_comb begin
        read_mux = 8'h00;
        for (int k = 0; k < LINE_CAPACITY; k++) begin
            read_mux = read_mux | cell_read[k];
        end
    end

    assign read_char = (i_req_type && (CMP_W'(i_read_index) < CMP_W'(r_count)))
                       ? read_mux : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cursor    <= n_cursor;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_cursor  <= OUT_CNT_W'(n_cursor);
            r_out_length  <= OUT_CNT_W'(n_count);
            r_out_char    <= read_char;
            r_out_dropped <= dropped;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_cursor         = r_out_cursor;
    assign o_line_length    = r_out_length;
    assign o_read_char      = r_out_char;
    assign o_insert_dropped = r_out_dropped;

endmodule
